// ----- rtl/core/simt_pkg.sv -----
// ----------------------------------------------------------------------------
// simt_pkg: shared types and constants of the sorted index merge table
// Entry layout, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package simt_pkg;

	localparam int unsigned ENTRIES = 1024;
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned EW = 128;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_MERGE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REPLACED = 3'd2,
		ST_APPENDED = 3'd3,
		ST_FOUND    = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_FULL     = 3'd6,
		ST_BADPOS   = 3'd7
	} status_t;

	localparam logic REG_DATA_BASE    = 1'b0;
	localparam logic REG_HEADER_BYTES = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_BS_RD,
		S_BS_CMP,
		S_OUT_RD,
		S_OUT_CAP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] packed_size;
		logic [31:0] size;
		logic [31:0] offset;
		logic [31:0] id;
	} entry_t;

	// key compare from the shared comparator
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

endpackage

// ----- rtl/core/sorted_index_merge_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_index_merge_table_core: sorted index table with insert/update merge
// Sequencer over one table RAM and one shared id comparator.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | s_axis_tdata, s_axis_tuser = cmd
// m_axis  | out | m_axis_tvalid/tready   | m_axis_tdata, m_axis_tuser = status
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A merge scans the entries in order, a read and a compare per scanned entry;
// an insert then moves the tail up with a read and a write per shifted entry.
// A lookup makes at most 11 probes. The single RAM port serializes these
// steps; a stalled result adds its wait.
// Reset clears the state, the count and the cfg registers; table contents and payload registers stay undefined.
// s_axis_tready is low while an item is in work or its result waits.
// ----------------------------------------------------------------------------
module sorted_index_merge_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] key_id, [63:32] entry_offset, [95:64] entry_size,
	// [127:96] entry_packed_size, [137:128] read_position, [143:138] zero
	input  logic [143:0] s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [9:0] position, [41:10] out_id, [73:42] out_offset, [105:74] out_size,
	// [137:106] out_packed_size, [148:138] entry_count, [151:149] zero
	output logic [151:0] m_axis_tdata,
	// [2:0] status
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import simt_pkg::*;

	state_t state_q, state_d;
	logic [31:0] data_base_q;
	logic [15:0] header_bytes_q;
	logic [CW-1:0] count_q;
	cmd_t cmd_q;
	entry_t in_q;
	logic [CW-1:0] idx_q;
	logic signed [CW:0] lo_q, hi_q;
	logic [CW-1:0] mid_w;
	entry_t hold_q;
	status_t st_q;
	logic [AW-1:0] pos_q;
	logic zero_q;
	entry_t res_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	entry_t ram_wdata, ram_rdata;
	cmp_t cmp;

	simt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);
	simt_cmp u_cmp (.key(in_q.id), .id(ram_rdata.id), .res(cmp));

	assign cfg_ready = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_DONE);
	assign m_axis_tuser = st_q;
	assign m_axis_tdata = {3'b000, count_q, res_q.packed_size, res_q.size,
		res_q.offset, res_q.id, pos_q};

	logic signed [CW:0] sum_w;
	assign sum_w = lo_q + hi_q;
	assign mid_w = sum_w[CW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			data_base_q <= '0;
			header_bytes_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DATA_BASE) data_base_q <= cfg_data;
				else header_bytes_q <= cfg_data[15:0];
			end
			if ((state_q == S_IDLE && s_axis_tvalid && s_axis_tuser == CMD_LOAD
				&& count_q != CW'(ENTRIES))
				|| (state_q == S_SCAN_CMP && cmd_q == CMD_MERGE && !cmp.eq
				&& (cmp.lt || idx_q + 1'b1 == count_q) && count_q != CW'(ENTRIES))
				|| (state_q == S_IDLE && s_axis_tvalid && s_axis_tuser == CMD_MERGE
				&& count_q == '0))
				count_q <= count_q + 1'b1;
		end
	end

	// payload and iteration registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_axis_tvalid) begin
				cmd_q <= cmd_t'(s_axis_tuser);
				in_q.id <= s_axis_tdata[31:0];
				in_q.offset <= (s_axis_tuser == CMD_MERGE)
					? data_base_q + s_axis_tdata[63:32] - {16'd0, header_bytes_q}
					: s_axis_tdata[63:32];
				in_q.size <= s_axis_tdata[95:64];
				in_q.packed_size <= s_axis_tdata[127:96];
				idx_q <= '0;
				lo_q <= '0;
				hi_q <= $signed({1'b0, count_q}) - (CW+1)'(1);
				zero_q <= 1'b0;
				pos_q <= count_q[AW-1:0];
				case (cmd_t'(s_axis_tuser))
					CMD_LOAD: st_q <= (count_q == CW'(ENTRIES)) ? ST_FULL : ST_OK;
					CMD_MERGE: st_q <= (count_q == CW'(ENTRIES)) ? ST_FULL : ST_APPENDED;
					CMD_READ: st_q <= ({1'b0, s_axis_tdata[137:128]} >= count_q)
						? ST_BADPOS : ST_OK;
					default: st_q <= ST_NOTFOUND;
				endcase
				if (count_q == CW'(ENTRIES) && s_axis_tuser == CMD_LOAD) begin
					zero_q <= 1'b1;
					pos_q <= '0;
				end
				if (s_axis_tuser == CMD_READ) begin
					pos_q <= s_axis_tdata[137:128];
					zero_q <= ({1'b0, s_axis_tdata[137:128]} >= count_q);
				end
				if (s_axis_tuser == CMD_LOOKUP) begin
					zero_q <= 1'b1;
					pos_q <= '0;
				end
			end
			S_SCAN_CMP: begin
				if (cmp.eq) begin
					st_q <= ST_REPLACED;
					pos_q <= idx_q[AW-1:0];
				end else if (cmp.lt) begin
					if (count_q == CW'(ENTRIES)) begin
						st_q <= ST_FULL; zero_q <= 1'b1; pos_q <= '0;
					end else begin
						st_q <= ST_INSERTED;
						pos_q <= idx_q[AW-1:0];
						hold_q <= in_q;
						idx_q <= idx_q;
					end
				end else if (idx_q + 1'b1 == count_q) begin
					if (count_q == CW'(ENTRIES)) begin
						st_q <= ST_FULL; zero_q <= 1'b1; pos_q <= '0;
					end else pos_q <= count_q[AW-1:0];
				end else idx_q <= idx_q + 1'b1;
			end
			S_SHIFT_WR: begin
				// carry displaced entry upward
				hold_q <= ram_rdata;
				idx_q <= idx_q + 1'b1;
			end
			S_BS_CMP: begin
				if (cmp.eq) begin
					st_q <= ST_FOUND; zero_q <= 1'b0; pos_q <= mid_w[AW-1:0];
				end else if (cmp.lt) hi_q <= $signed({1'b0, mid_w}) - (CW+1)'(1);
				else lo_q <= $signed({1'b0, mid_w}) + (CW+1)'(1);
			end
			S_OUT_CAP: res_q <= zero_q ? '0 : ram_rdata;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = pos_q;
		ram_wdata = in_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid) begin
				case (cmd_t'(s_axis_tuser))
					CMD_LOAD: begin
						ram_we = (count_q != CW'(ENTRIES));
						ram_addr = count_q[AW-1:0];
						ram_wdata = s_axis_tdata[127:0];
						state_d = S_OUT_RD;
					end
					CMD_MERGE: state_d = (count_q == '0) ? S_SHIFT_RD : S_SCAN_RD;
					CMD_READ: state_d = S_OUT_RD;
					default: state_d = (count_q == '0) ? S_OUT_RD : S_BS_RD;
				endcase
			end
			S_SCAN_RD: begin
				ram_addr = idx_q[AW-1:0];
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				ram_addr = idx_q[AW-1:0];
				if (cmp.eq) begin
					ram_we = 1'b1;
					ram_wdata = {in_q.packed_size, in_q.size, in_q.offset, ram_rdata.id};
					state_d = S_OUT_RD;
				end else if (cmp.lt) begin
					state_d = (count_q == CW'(ENTRIES)) ? S_OUT_RD : S_SHIFT_WR;
				end else if (idx_q + 1'b1 == count_q) begin
					ram_we = (count_q != CW'(ENTRIES));
					ram_addr = count_q[AW-1:0];
					state_d = S_OUT_RD;
				end else state_d = S_SCAN_RD;
			end
			S_SHIFT_RD: begin
				// empty table: plain append at position 0
				ram_we = 1'b1;
				ram_addr = '0;
				state_d = S_OUT_RD;
			end
			S_SHIFT_WR: begin
				// read of idx was issued last cycle; write carried entry in place
				ram_we = 1'b1;
				ram_addr = idx_q[AW-1:0];
				ram_wdata = hold_q;
				state_d = (idx_q + 1'b1 == count_q) ? S_OUT_RD : S_SCAN_RD;
			end
			S_BS_RD: begin
				ram_addr = mid_w[AW-1:0];
				state_d = S_BS_CMP;
			end
			S_BS_CMP: begin
				if (cmp.eq || mid_w == '0 && cmp.lt) state_d = S_OUT_RD;
				else if (cmp.lt) state_d = ($signed({1'b0, mid_w}) - 1 < lo_q)
					? S_OUT_RD : S_BS_RD;
				else state_d = ($signed({1'b0, mid_w}) + 1 > hi_q) ? S_OUT_RD : S_BS_RD;
			end
			S_OUT_RD: state_d = S_OUT_CAP;
			S_OUT_CAP: state_d = S_DONE;
			S_DONE: if (m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// shift loop rereads next slot through the scan read state
		if (state_q == S_SCAN_RD && st_q == ST_INSERTED) state_d = S_SHIFT_WR;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_SCAN_CMP) |=> $stable(count_q))
		else $error("count changed outside an update point");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while result pending");
endmodule

// ----- rtl/core/simt_ram.sv -----
// ----------------------------------------------------------------------------
// simt_ram: generic single-port RAM
// One access per cycle (a write also reads the old word), registered read data.
// ----------------------------------------------------------------------------
module simt_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/core/simt_cmp.sv -----
// ----------------------------------------------------------------------------
// simt_cmp: shared id comparator
// Compares the search key against one stored id.
// ----------------------------------------------------------------------------
module simt_cmp (
	input  logic [31:0]         key,
	input  logic [31:0]         id,
	output simt_pkg::cmp_t      res
);
	import simt_pkg::*;

	always_comb begin
		res.eq = (key == id);
		res.lt = (key < id);
	end
endmodule
